@@ design/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Input word kinds. A value of three is treated like an end without a byte.
  typedef enum logic [1:0] {
    ModeByte  = 2'd0,
    ModeFinal = 2'd1,
    ModeEnd   = 2'd2
  } mode_e;

  // Decoder constants.
  localparam logic [7:0]  LeadTwoMin   = 8'hC2;
  localparam logic [7:0]  LeadTwoMax   = 8'hDF;
  localparam logic [7:0]  LeadThreeMin = 8'hE0;
  localparam logic [7:0]  LeadThreeMax = 8'hEF;
  localparam logic [7:0]  LeadFourMin  = 8'hF0;
  localparam logic [7:0]  LeadFourMax  = 8'hF4;
  localparam logic [7:0]  ContMask     = 8'hC0;
  localparam logic [7:0]  ContTag      = 8'h80;
  localparam logic [20:0] MinTwo       = 21'h000080;
  localparam logic [20:0] MinThree     = 21'h000800;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [20:0] CodeMax      = 21'h10FFFF;
  localparam logic [20:0] SurFirst     = 21'h00D800;
  localparam logic [20:0] SurLast      = 21'h00DFFF;
  localparam logic [20:0] BmpMax       = 21'h00FFFF;
  localparam logic [15:0] HighSurBase  = 16'hD800;
  localparam logic [15:0] LowSurBase   = 16'hDC00;

  // Result queue sizing.
  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Decoder state carried between words.
  typedef struct packed {
    logic [20:0] accum;
    logic [1:0]  pend;
    logic [1:0]  cls;
    logic        err;
  } dec_state_t;

  // One result word.
  typedef struct packed {
    logic [15:0] unit;
    logic        is_end;
    logic        status;
    logic        last;
  } result_t;

  // Everything the decoder produces for one input word.
  typedef struct packed {
    logic [1:0]          cnt;
    result_t [MaxRes-1:0] res;
    dec_state_t          nxt;
  } dec_out_t;

endpackage

@@ design/utf8_to_utf16_validating_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_validating_decoder
// Validating UTF-8 to UTF-16 stream decoder with end-of-string status.
// ----------------------------------------------------------------------------
// The block accepts one UTF-8 byte per cycle and emits UTF-16 code units, one
// word per cycle. A byte is held in an input register, decoded in one pass of
// shift, mask and compare logic, and its zero to three result words are
// written into a four-word result queue that drives the output port. Input
// flows at one word per cycle as long as each byte yields at most one output
// word on average; a byte that completes a supplementary code point (two
// surrogate words) or that also closes the string (an extra end word) yields
// a burst of output words, and the queue depth sets how much of that burst
// is absorbed before the input stalls. Each byte is held in the input register
// and its result words in the queue. Malformed input (bad lead bytes, bad
// continuation bytes, overlong forms, surrogate code points, values above
// 10FFFF, sequences cut off by the end) sets a sticky error: no code units are
// emitted for the rest of the string, and its end word reports malformed
// status so the consumer can drop the string. Every string ends with one end
// word, after which all decoder state is back at its reset values.
// ----------------------------------------------------------------------------
module utf8_to_utf16_validating_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser,   // [0] is_end, [1] status
  output logic        m_axis_tlast    // last_of_run
);
  import u8u16_pkg::*;

  // Input register: one word waiting for decode.
  logic       in_valid_q, in_valid_d;
  logic [1:0] in_mode_q;
  logic [7:0] in_byte_q;

  // Sequence state between bytes of a string.
  dec_state_t state_q;

  dec_out_t   dec;
  logic       room;
  logic       consume;
  logic [1:0] push_cnt;
  result_t    head;

  u8u16_dec u_dec (
    .state_i (state_q),
    .mode_i  (in_mode_q),
    .byte_i  (in_byte_q),
    .out_o   (dec)
  );

  // A held word is decoded once the queue can take its worst-case burst.
  assign consume       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || consume;
  assign in_valid_d    = s_axis_tvalid ? 1'b1 : (in_valid_q && !consume);
  assign push_cnt      = consume ? dec.cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= in_valid_d;
      end
      if (consume) begin
        state_q <= dec.nxt;
      end
    end
  end

  // The payload loads whenever the input register is free to take a word.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  u8u16_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (dec.res),
    .room_o      (room),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .head_o      (head)
  );

  assign m_axis_tdata = head.unit;
  assign m_axis_tuser = {head.status, head.is_end};
  assign m_axis_tlast = head.last;

  // A word that could not be decoded stays in the input register unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !consume) |=> (in_valid_q && $stable(in_mode_q) && $stable(in_byte_q)))
    else $error("held input word changed before decode");

  // Closing a string returns the decoder state to reset.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (in_mode_q != ModeByte)) |=> (state_q == '0))
    else $error("decoder state not cleared after end of string");

  // Code units are never produced while an error is pending.
  a_no_units_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && state_q.err && (in_mode_q == ModeByte)) |-> (dec.cnt == 2'd0))
    else $error("code unit produced after an error");

endmodule

@@ design/u8u16_dec.sv @@
// ----------------------------------------------------------------------------
// u8u16_dec
// Combinational decode of one UTF-8 byte against the current sequence state.
// ----------------------------------------------------------------------------
module u8u16_dec (
  input  u8u16_pkg::dec_state_t state_i,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            byte_i,
  output u8u16_pkg::dec_out_t   out_o
);
  import u8u16_pkg::*;

  logic        has_byte;
  logic        has_end;
  logic [1:0]  nb;
  logic [15:0] u0;
  logic [15:0] u1;
  logic [20:0] acc_sh;
  logic [20:0] minimum;
  logic [20:0] cp_off;
  logic        cp_bad;
  dec_state_t  nxt;
  result_t     end_res;
  logic [1:0]  cnt;

  assign has_byte = (mode_i == ModeByte) || (mode_i == ModeFinal);
  assign has_end  = (mode_i != ModeByte);
  assign acc_sh   = {state_i.accum[14:0], byte_i[5:0]};
  assign cp_off   = acc_sh - SuppBase;

  always_comb begin
    unique case (state_i.cls)
      2'd1:    minimum = MinTwo;
      2'd2:    minimum = MinThree;
      default: minimum = SuppBase;
    endcase
  end

  assign cp_bad = (acc_sh < minimum) || (acc_sh > CodeMax) ||
                  ((acc_sh >= SurFirst) && (acc_sh <= SurLast));

  always_comb begin
    nxt = state_i;
    nb  = 2'd0;
    u0  = '0;
    u1  = '0;
    if (has_byte && !state_i.err) begin
      if (state_i.pend == 2'd0) begin
        if (!byte_i[7]) begin
          nb = 2'd1;
          u0 = {8'h00, byte_i};
        end else if (byte_i >= LeadTwoMin && byte_i <= LeadTwoMax) begin
          nxt.accum = {16'h0000, byte_i[4:0]};
          nxt.pend  = 2'd1;
          nxt.cls   = 2'd1;
        end else if (byte_i >= LeadThreeMin && byte_i <= LeadThreeMax) begin
          nxt.accum = {17'h00000, byte_i[3:0]};
          nxt.pend  = 2'd2;
          nxt.cls   = 2'd2;
        end else if (byte_i >= LeadFourMin && byte_i <= LeadFourMax) begin
          nxt.accum = {18'h00000, byte_i[2:0]};
          nxt.pend  = 2'd3;
          nxt.cls   = 2'd3;
        end else begin
          nxt = '{accum: '0, pend: 2'd0, cls: 2'd0, err: 1'b1};
        end
      end else if ((byte_i & ContMask) != ContTag) begin
        nxt = '{accum: '0, pend: 2'd0, cls: 2'd0, err: 1'b1};
      end else if (state_i.pend != 2'd1) begin
        nxt.accum = acc_sh;
        nxt.pend  = state_i.pend - 2'd1;
      end else begin
        // Sequence complete: range check, then one unit or a surrogate pair.
        nxt.accum = '0;
        nxt.pend  = 2'd0;
        nxt.cls   = 2'd0;
        if (cp_bad) begin
          nxt.err = 1'b1;
        end else if (acc_sh <= BmpMax) begin
          nb = 2'd1;
          u0 = acc_sh[15:0];
        end else begin
          nb = 2'd2;
          u0 = HighSurBase + {6'b000000, cp_off[19:10]};
          u1 = LowSurBase | {6'b000000, cp_off[9:0]};
        end
      end
    end
    end_res = '{unit: '0, is_end: 1'b1,
                status: nxt.err | (nxt.pend != 2'd0), last: 1'b0};
    if (has_end) begin
      nxt = '0;
    end
  end

  assign cnt = nb + {1'b0, has_end};

  always_comb begin
    out_o.cnt = cnt;
    out_o.nxt = nxt;
    out_o.res[0] = (nb != 2'd0) ? '{unit: u0, is_end: 1'b0, status: 1'b0, last: 1'b0}
                                : end_res;
    out_o.res[1] = (nb == 2'd2) ? '{unit: u1, is_end: 1'b0, status: 1'b0, last: 1'b0}
                                : end_res;
    out_o.res[2] = end_res;
    for (int i = 0; i < MaxRes; i++) begin
      out_o.res[i].last = (cnt == 2'(i + 1));
    end
  end

endmodule

@@ design/u8u16_fifo.sv @@
// ----------------------------------------------------------------------------
// u8u16_fifo
// Small result queue that takes up to three words per cycle and gives one.
// ----------------------------------------------------------------------------
module u8u16_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [1:0]                             push_cnt_i,
  input  u8u16_pkg::result_t [u8u16_pkg::MaxRes-1:0] push_data_i,
  output logic                                   room_o,
  input  logic                                   pop_i,
  output logic                                   valid_o,
  output u8u16_pkg::result_t                     head_o
);
  import u8u16_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rptr_q];
  assign room_o  = (count_q <= QCntW'(QDepth - MaxRes));

  assign wptr_d  = wptr_q + QPtrW'(push_cnt_i);
  assign rptr_d  = rptr_q + QPtrW'(pop);
  assign count_d = count_q + QCntW'(push_cnt_i) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_cnt_i) begin
        mem_q[wptr_q + QPtrW'(i)] <= push_data_i[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue count above depth");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("result queue written without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) + QCntW'($past(push_cnt_i)) - QCntW'($past(pop))))
    else $error("result queue count lost track");

endmodule
